// ----- hdl/ppgfe_pkg.sv -----
// Package for the optical sensor sample front end.
// Holds the field widths, command and register codes and the result record.
// No dependencies.
package ppgfe_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 100;

    localparam int SAMPLE_W    = 18;
    localparam int WORD_W      = 48;
    localparam int SUM_W       = 20;
    localparam int LEVEL_ACC_W = 23;
    localparam int CFG_INDEX_W = 2;

    localparam int RED_LSB = 24;
    localparam int IR_LSB  = 0;

    localparam logic [SAMPLE_W-1:0] ENTER_RESET = 18'd8000;
    localparam logic [SAMPLE_W-1:0] EXIT_RESET  = 18'd6000;

    localparam logic [1:0] GROUP_LAST = 2'd3;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } ppgfe_cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTACT_ENTER = 2'd0,
        REG_CONTACT_EXIT  = 2'd1
    } ppgfe_reg_t;

    typedef struct packed {
        logic                contact;
        logic [SAMPLE_W-1:0] dc_average;
        logic                decimated_ready;
        logic [SAMPLE_W-1:0] report_red;
        logic [SAMPLE_W-1:0] report_ir;
        logic                read_valid;
    } ppgfe_res_t;

endpackage

// ----- hdl/ppg_sample_front_end.sv -----
// Optical sensor sample front end: unpacking, DC tracking, contact detection,
// decimation by four into a ring store held in one synchronous memory.
// Depends on ppgfe_pkg.
//
//  Channel   Direction  Signals                                   Purpose
//  s_        in         s_valid/s_ready, command, word, offset    sample push or window read
//  m_        out        m_valid/m_ready, nine result fields       one result per request
//  cfg_      in         cfg_valid/cfg_ready, cfg_index, cfg_data  contact thresholds
//
// One request is accepted every cycle unless a stalled output holds the read stage full;
// each result passes the read stage, where the memory is read, and the output register.
// Reset clears all control and tracking state; the memory is not cleared, and the
// fill count keeps reads inside the written entries.
// A stalled output holds the result; a second request waits in the read stage.
module ppg_sample_front_end #(
    parameter int  WINDOW_DEPTH = ppgfe_pkg::DEFAULT_WINDOW_DEPTH,
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [ppgfe_pkg::WORD_W-1:0]        s_sample_word,
    input  logic [FILL_W-1:0]                   s_window_offset,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_contact,
    output logic [ppgfe_pkg::SAMPLE_W-1:0]      m_dc_average,
    output logic                                m_decimated_ready,
    output logic [ppgfe_pkg::SAMPLE_W-1:0]      m_report_red,
    output logic [ppgfe_pkg::SAMPLE_W-1:0]      m_report_ir,
    output logic [FILL_W-1:0]                   m_window_fill,
    output logic                                m_read_valid,
    output logic [ppgfe_pkg::SAMPLE_W-1:0]      m_read_red,
    output logic [ppgfe_pkg::SAMPLE_W-1:0]      m_read_ir,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppgfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ppgfe_pkg::SAMPLE_W-1:0]      cfg_data
);
    import ppgfe_pkg::*;

    localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
    localparam int RSUM_W  = FILL_W + 1;
    localparam int ENTRY_W = 2 * SAMPLE_W;

    logic [SAMPLE_W-1:0] enter_level_reg;
    logic [SAMPLE_W-1:0] exit_level_reg;

    logic [SAMPLE_W-1:0] ir_level_reg;
    logic                touching_reg;
    logic [SUM_W-1:0]    ir_sum_reg;
    logic [SUM_W-1:0]    red_sum_reg;
    logic [1:0]          group_count_reg;
    logic [SAMPLE_W-1:0] held_ir_reg;
    logic [SAMPLE_W-1:0] held_red_reg;
    logic [ADDR_W-1:0]   write_slot_reg;
    logic [FILL_W-1:0]   fill_reg;

    logic [ENTRY_W-1:0]  store_mem [WINDOW_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic                a_valid_reg;
    ppgfe_res_t          a_res_reg;
    ppgfe_res_t          a_res_next;
    logic [FILL_W-1:0]   a_fill_reg;
    logic [FILL_W-1:0]   fill_next;

    logic                m_valid_reg;
    ppgfe_res_t          b_res_reg;
    logic [FILL_W-1:0]   b_fill_reg;
    logic [SAMPLE_W-1:0] b_red_reg;
    logic [SAMPLE_W-1:0] b_ir_reg;

    logic                b_free;
    logic                accept;
    logic                is_read;
    logic                is_push;
    logic [SAMPLE_W-1:0] red_raw;
    logic [SAMPLE_W-1:0] ir_raw;
    logic [LEVEL_ACC_W-1:0] level_acc;
    logic [SAMPLE_W-1:0] ir_level_next;
    logic                touching_next;
    logic                group_done;
    logic [SUM_W-1:0]    ir_sum_add;
    logic [SUM_W-1:0]    red_sum_add;
    logic [SAMPLE_W-1:0] held_ir_next;
    logic [SAMPLE_W-1:0] held_red_next;
    logic [ADDR_W-1:0]   write_slot_next;
    logic                window_full;
    logic [ADDR_W-1:0]   oldest_slot;
    logic [RSUM_W-1:0]   rd_sum;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_hit;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_level_reg <= ENTER_RESET;
            exit_level_reg  <= EXIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_CONTACT_ENTER) begin
                enter_level_reg <= cfg_data;
            end else if (cfg_index == REG_CONTACT_EXIT) begin
                exit_level_reg <= cfg_data;
            end
        end
    end

    assign b_free  = !m_valid_reg || m_ready;
    assign s_ready = aresetn && (!a_valid_reg || b_free);
    assign accept  = s_valid && s_ready;
    assign is_read = (ppgfe_cmd_t'(s_command) == CMD_READ);
    assign is_push = !is_read;

    always_comb begin
        red_raw = '0;
        ir_raw  = '0;
        if (is_push) begin
            red_raw = s_sample_word[RED_LSB +: SAMPLE_W];
            ir_raw  = s_sample_word[IR_LSB +: SAMPLE_W];
        end
    end

    assign level_acc = {1'b0, ir_level_reg, 4'b0000} - {5'b00000, ir_level_reg}
                       + {5'b00000, ir_raw};

    always_comb begin
        ir_level_next = ir_level_reg;
        touching_next = touching_reg;
        if (is_push) begin
            if (ir_level_reg == '0) begin
                ir_level_next = ir_raw;
            end else begin
                ir_level_next = level_acc[4 +: SAMPLE_W];
            end
            if (!touching_next && ir_level_next > enter_level_reg) begin
                touching_next = 1'b1;
            end
            if (touching_next && ir_level_next < exit_level_reg) begin
                touching_next = 1'b0;
            end
        end
    end

    assign group_done  = is_push && (group_count_reg == GROUP_LAST);
    assign ir_sum_add  = ir_sum_reg + {2'b00, ir_raw};
    assign red_sum_add = red_sum_reg + {2'b00, red_raw};
    assign window_full = (fill_reg == FILL_W'(WINDOW_DEPTH));

    always_comb begin
        held_ir_next    = held_ir_reg;
        held_red_next   = held_red_reg;
        write_slot_next = write_slot_reg;
        fill_next       = fill_reg;
        if (group_done) begin
            held_ir_next  = ir_sum_add[2 +: SAMPLE_W];
            held_red_next = red_sum_add[2 +: SAMPLE_W];
            if (write_slot_reg == ADDR_W'(WINDOW_DEPTH - 1)) begin
                write_slot_next = '0;
            end else begin
                write_slot_next = write_slot_reg + ADDR_W'(1);
            end
            if (!window_full) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_level_reg    <= '0;
            touching_reg    <= 1'b0;
            ir_sum_reg      <= '0;
            red_sum_reg     <= '0;
            group_count_reg <= '0;
            held_ir_reg     <= '0;
            held_red_reg    <= '0;
            write_slot_reg  <= '0;
            fill_reg        <= '0;
        end else if (accept && is_push) begin
            ir_level_reg    <= ir_level_next;
            touching_reg    <= touching_next;
            held_ir_reg     <= held_ir_next;
            held_red_reg    <= held_red_next;
            write_slot_reg  <= write_slot_next;
            fill_reg        <= fill_next;
            if (group_done) begin
                ir_sum_reg      <= '0;
                red_sum_reg     <= '0;
                group_count_reg <= '0;
            end else begin
                ir_sum_reg      <= ir_sum_add;
                red_sum_reg     <= red_sum_add;
                group_count_reg <= group_count_reg + 2'd1;
            end
        end
    end

    // Before the window wraps the oldest entry sits in slot zero.
    assign oldest_slot = window_full ? write_slot_reg : '0;
    assign rd_sum      = RSUM_W'(oldest_slot) + RSUM_W'(s_window_offset);
    assign rd_hit      = is_read && (s_window_offset < fill_reg);

    always_comb begin
        if (rd_sum >= RSUM_W'(WINDOW_DEPTH)) begin
            rd_addr = ADDR_W'(rd_sum - RSUM_W'(WINDOW_DEPTH));
        end else begin
            rd_addr = ADDR_W'(rd_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && group_done) begin
            store_mem[write_slot_reg] <= {held_red_next, held_ir_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_read) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb begin
        a_res_next.contact         = touching_next;
        a_res_next.dc_average      = ir_level_next;
        a_res_next.decimated_ready = group_done;
        a_res_next.report_red      = (held_red_next != '0) ? held_red_next : red_raw;
        a_res_next.report_ir       = (held_ir_next != '0) ? held_ir_next : ir_raw;
        a_res_next.read_valid      = rd_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (b_free) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_res_reg  <= a_res_next;
            a_fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_free) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_free && a_valid_reg) begin
            b_res_reg  <= a_res_reg;
            b_fill_reg <= a_fill_reg;
            if (a_res_reg.read_valid) begin
                b_red_reg <= rd_data_reg[SAMPLE_W +: SAMPLE_W];
                b_ir_reg  <= rd_data_reg[0 +: SAMPLE_W];
            end else begin
                b_red_reg <= '0;
                b_ir_reg  <= '0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_contact         = b_res_reg.contact;
    assign m_dc_average      = b_res_reg.dc_average;
    assign m_decimated_ready = b_res_reg.decimated_ready;
    assign m_report_red      = b_res_reg.report_red;
    assign m_report_ir       = b_res_reg.report_ir;
    assign m_window_fill     = b_fill_reg;
    assign m_read_valid      = b_res_reg.read_valid;
    assign m_read_red        = b_red_reg;
    assign m_read_ir         = b_ir_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("Window fill count exceeds the window depth.");

    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !window_full |-> (FILL_W'(write_slot_reg) == fill_reg))
        else $error("Write slot and fill count disagree before the window wraps.");

    a_group_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && group_done) |=> (fill_reg != '0))
        else $error("A completed group left the window empty.");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(b_res_reg.read_valid && b_res_reg.decimated_ready))
        else $error("A result claims both a read hit and a finished group.");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !b_free) |=> (a_valid_reg && $stable(rd_data_reg)))
        else $error("The read stage lost its request or data during a stall.");

endmodule
